>>> design/tdcg_pkg.sv
// tdcg_pkg: shared types and constants for the teleop drive command gate
// holds register indexes, drive kind codes and the structs passed between modules
// no dependencies
`default_nettype none

package tdcg_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_REQUIRE_ENABLE    = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_TURBO_AVAILABLE   = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_STOP_DELAY        = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_AXIS_USED_MASK    = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_USED_MASK   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_SCALE_NORMAL_WORD = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_SCALE_BOOST_WORD  = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_WORD       = 4'd7;

  localparam logic [63:0] SCALE_NORMAL_RST = 64'h0000_0000_1666_0800;
  localparam logic [63:0] SCALE_BOOST_RST  = 64'h0000_0000_0CCD_1000;
  localparam logic [47:0] OFFSET_RST       = 48'h0666_0000_0000;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ACTIVE = 2'd1,
    KIND_STOP   = 2'd2
  } drive_kind_e;

  typedef struct packed {
    logic        require_enable;
    logic        turbo_available;
    logic [15:0] stop_delay;
    logic [3:0]  axis_used_mask;
    logic [3:0]  light_used_mask;
    logic [63:0] scale_normal;
    logic [63:0] scale_boost;
    logic [47:0] offset;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] axis_linear;
    logic signed [15:0] axis_steer;
    logic signed [15:0] axis_steer_fine;
    logic signed [15:0] axis_steer_vel;
    logic               enable_pressed;
    logic               turbo_pressed;
    logic [3:0]         light_buttons;
    logic [31:0]        time_ms;
  } sample_t;

  typedef struct packed {
    logic               active;
    logic signed [15:0] speed;
    logic signed [15:0] steer_angle;
    logic signed [15:0] steering_velocity;
  } cmd_t;

  typedef struct packed {
    drive_kind_e kind;
    logic [3:0]  light_changed;
    logic [3:0]  light_state;
  } gate_status_t;

  typedef struct packed {
    drive_kind_e        kind;
    logic signed [15:0] speed;
    logic signed [15:0] steer_angle;
    logic signed [15:0] steering_velocity;
    logic [3:0]         light_changed;
    logic [3:0]         light_state;
  } result_t;

endpackage

`default_nettype wire

>>> design/tdcg_cfg_regs.sv
// tdcg_cfg_regs: configuration register file of the drive command gate
// decodes index/data writes into the cfg_t struct; uses tdcg_pkg
`default_nettype none

module tdcg_cfg_regs import tdcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_REQUIRE_ENABLE:    cfg_d.require_enable    = cfg_data_i[0];
        REG_TURBO_AVAILABLE:   cfg_d.turbo_available   = cfg_data_i[0];
        REG_STOP_DELAY:        cfg_d.stop_delay        = cfg_data_i[15:0];
        REG_AXIS_USED_MASK:    cfg_d.axis_used_mask    = cfg_data_i[3:0];
        REG_LIGHT_USED_MASK:   cfg_d.light_used_mask   = cfg_data_i[3:0];
        REG_SCALE_NORMAL_WORD: cfg_d.scale_normal      = cfg_data_i;
        REG_SCALE_BOOST_WORD:  cfg_d.scale_boost       = cfg_data_i;
        REG_OFFSET_WORD:       cfg_d.offset            = cfg_data_i[47:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.require_enable    <= 1'b1;
      cfg_q.turbo_available   <= 1'b0;
      cfg_q.stop_delay        <= '0;
      cfg_q.axis_used_mask    <= 4'd3;
      cfg_q.light_used_mask   <= '0;
      cfg_q.scale_normal      <= SCALE_NORMAL_RST;
      cfg_q.scale_boost       <= SCALE_BOOST_RST;
      cfg_q.offset            <= OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/tdcg_drive_calc.sv
// tdcg_drive_calc: combinational drive command math for one joystick sample
// scales axes, rounds to Q4.12, adds offsets and saturates; uses tdcg_pkg
`default_nettype none

module tdcg_drive_calc import tdcg_pkg::*; (
  input  cfg_t    cfg_i,
  input  sample_t sample_i,
  output cmd_t    cmd_o
);

  // Q1.15 times Q4.12, rounded half up to Q4.12
  function automatic logic signed [16:0] scaled_term(
    input logic signed [15:0] axis,
    input logic signed [15:0] scale,
    input logic               used
  );
    logic signed [31:0] prod;
    logic signed [31:0] biased;
    prod   = axis * scale;
    biased = prod + 32'sd16384;
    return used ? signed'(biased[31:15]) : 17'sd0;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7fff;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end else begin
      return signed'(v[15:0]);
    end
  endfunction

  logic               turbo_act;
  logic [63:0]        scale_word;
  logic signed [16:0] t_lin;
  logic signed [16:0] t_steer;
  logic signed [16:0] t_fine;
  logic signed [16:0] t_vel;
  logic signed [18:0] t_vel_w;
  logic signed [18:0] t_vel_abs;
  logic signed [15:0] off_lin;
  logic signed [15:0] off_steer;
  logic signed [15:0] off_vel;
  logic signed [18:0] sum_lin;
  logic signed [18:0] sum_steer;
  logic signed [18:0] sum_vel;

  assign turbo_act  = cfg_i.turbo_available & sample_i.turbo_pressed;
  assign scale_word = turbo_act ? cfg_i.scale_boost : cfg_i.scale_normal;

  assign t_lin   = scaled_term(sample_i.axis_linear, signed'(scale_word[15:0]),
                               cfg_i.axis_used_mask[0]);
  assign t_steer = scaled_term(sample_i.axis_steer, signed'(scale_word[31:16]),
                               cfg_i.axis_used_mask[1]);
  assign t_fine  = scaled_term(sample_i.axis_steer_fine, signed'(scale_word[47:32]),
                               cfg_i.axis_used_mask[2]);
  assign t_vel   = scaled_term(sample_i.axis_steer_vel, signed'(scale_word[63:48]),
                               cfg_i.axis_used_mask[3]);

  assign t_vel_w   = 19'(t_vel);
  assign t_vel_abs = t_vel_w[18] ? -t_vel_w : t_vel_w;

  assign off_lin   = signed'(cfg_i.offset[15:0]);
  assign off_steer = signed'(cfg_i.offset[31:16]);
  assign off_vel   = signed'(cfg_i.offset[47:32]);

  assign sum_lin   = 19'(off_lin) + 19'(t_lin);
  assign sum_steer = 19'(off_steer) + 19'(t_steer) + 19'(t_fine);
  assign sum_vel   = 19'(off_vel) + t_vel_abs;

  assign cmd_o.active = turbo_act | ~cfg_i.require_enable | sample_i.enable_pressed;
  assign cmd_o.speed             = sat16(sum_lin);
  assign cmd_o.steer_angle       = sat16(sum_steer);
  assign cmd_o.steering_velocity = sat16(sum_vel);

endmodule

`default_nettype wire

>>> design/tdcg_gate_state.sv
// tdcg_gate_state: dead-man failsafe timing and light toggle state
// decides the drive kind and updates its state as each request leaves; uses tdcg_pkg
`default_nettype none

module tdcg_gate_state import tdcg_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  cfg_t        cfg_i,
  input  sample_t     sample_i,
  input  wire logic   active_i,
  input  wire logic   update_i,
  output gate_status_t status_o
);

  logic [3:0]  prev_buttons_q, prev_buttons_d;
  logic [3:0]  light_on_q, light_on_d;
  logic        stop_sent_q, stop_sent_d;
  logic [31:0] last_time_q, last_time_d;

  logic [3:0]  rise;
  logic [31:0] since;
  drive_kind_e kind;

  assign rise  = sample_i.light_buttons & ~prev_buttons_q & cfg_i.light_used_mask;
  assign since = sample_i.time_ms - last_time_q;

  always_comb begin
    if (active_i) begin
      kind = KIND_ACTIVE;
    end else if (!stop_sent_q && (since > {16'd0, cfg_i.stop_delay})) begin
      kind = KIND_STOP;
    end else begin
      kind = KIND_NONE;
    end
  end

  always_comb begin
    prev_buttons_d = prev_buttons_q;
    light_on_d     = light_on_q;
    stop_sent_d    = stop_sent_q;
    last_time_d    = last_time_q;
    if (update_i) begin
      prev_buttons_d = sample_i.light_buttons;
      light_on_d     = light_on_q ^ rise;
      if (active_i) begin
        stop_sent_d = 1'b0;
        last_time_d = sample_i.time_ms;
      end else if (kind == KIND_STOP) begin
        stop_sent_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_buttons_q <= '0;
      light_on_q     <= '0;
      stop_sent_q    <= 1'b0;
      last_time_q    <= '0;
    end else begin
      prev_buttons_q <= prev_buttons_d;
      light_on_q     <= light_on_d;
      stop_sent_q    <= stop_sent_d;
      last_time_q    <= last_time_d;
    end
  end

  assign status_o.kind          = kind;
  assign status_o.light_changed = rise;
  assign status_o.light_state   = light_on_q ^ rise;

endmodule

`default_nettype wire

>>> design/teleop_drive_command_gate.sv
// teleop_drive_command_gate: joystick drive command gate with dead-man button
// an accepted request waits in the input register s1_q, then moves to the result register out_q once that is free
// throughput: one request per cycle; the output register lets a new request in while
// a result waits, and ready only drops when both registers are full and output stalls
// reset: config registers take their documented defaults, lights off, timer state zero
// uses tdcg_pkg, tdcg_cfg_regs, tdcg_drive_calc, tdcg_gate_state
`default_nettype none

module teleop_drive_command_gate import tdcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic signed [15:0]  axis_linear_i,
  input  wire logic signed [15:0]  axis_steer_i,
  input  wire logic signed [15:0]  axis_steer_fine_i,
  input  wire logic signed [15:0]  axis_steer_vel_i,
  input  wire logic                enable_pressed_i,
  input  wire logic                turbo_pressed_i,
  input  wire logic [3:0]          light_buttons_i,
  input  wire logic [31:0]         time_ms_i,

  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [1:0]          drive_kind_o,
  output      logic signed [15:0]  speed_o,
  output      logic signed [15:0]  steer_angle_o,
  output      logic signed [15:0]  steering_velocity_o,
  output      logic [3:0]          light_changed_o,
  output      logic [3:0]          light_state_o
);

  cfg_t         cfg;
  cmd_t         cmd;
  gate_status_t status;
  result_t      result_d;

  logic    s1_valid_q, s1_valid_d;
  sample_t s1_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic out_load;
  logic in_accept;

  assign cfg_ready_o = 1'b1;

  tdcg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_load   = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | out_load;
  assign in_accept  = in_valid_i & in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.axis_linear     <= axis_linear_i;
      s1_q.axis_steer      <= axis_steer_i;
      s1_q.axis_steer_fine <= axis_steer_fine_i;
      s1_q.axis_steer_vel  <= axis_steer_vel_i;
      s1_q.enable_pressed  <= enable_pressed_i;
      s1_q.turbo_pressed   <= turbo_pressed_i;
      s1_q.light_buttons   <= light_buttons_i;
      s1_q.time_ms         <= time_ms_i;
    end
  end

  tdcg_drive_calc u_drive_calc (
    .cfg_i    (cfg),
    .sample_i (s1_q),
    .cmd_o    (cmd)
  );

  tdcg_gate_state u_gate_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (s1_q),
    .active_i (cmd.active),
    .update_i (out_load),
    .status_o (status)
  );

  always_comb begin
    result_d.kind              = status.kind;
    result_d.light_changed     = status.light_changed;
    result_d.light_state       = status.light_state;
    result_d.speed             = '0;
    result_d.steer_angle       = '0;
    result_d.steering_velocity = '0;
    if (cmd.active) begin
      result_d.speed             = cmd.speed;
      result_d.steer_angle       = cmd.steer_angle;
      result_d.steering_velocity = cmd.steering_velocity;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign drive_kind_o        = out_q.kind;
  assign speed_o             = out_q.speed;
  assign steer_angle_o       = out_q.steer_angle;
  assign steering_velocity_o = out_q.steering_velocity;
  assign light_changed_o     = out_q.light_changed;
  assign light_state_o       = out_q.light_state;

endmodule

`default_nettype wire
